@@ sv/rcpc_pkg.sv @@
// shared constants and types for the random cycle pointer chase
package rcpc_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int STEP_W     = 32;
    localparam int DIV_CNT_W  = $clog2(WORD_W);
    localparam int CFG_IDX_W  = 1;

    localparam logic [WORD_W-1:0] SEED_RESET = 64'd20260923;
    localparam logic [WORD_W-1:0] MIX_MULT   = 64'd2685821657736338717;
    localparam logic [CNT_W-1:0]  NODE_RESET = CNT_W'(MAX_NODES);

    localparam int SHIFT_A = 12;
    localparam int SHIFT_B = 25;
    localparam int SHIFT_C = 27;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEED       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd1;

    // generator control
    typedef struct packed {
        logic reload;
        logic draw;
    } rng_ctrl_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

endpackage

@@ sv/rcpc_in_if.sv @@
// request channel carrying the step count
interface rcpc_in_if;
    import rcpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_count;
    modport source (output valid, output step_count, input ready);
    modport sink (input valid, input step_count, output ready);
endinterface

@@ sv/rcpc_out_if.sv @@
// result channel carrying the final index
interface rcpc_out_if;
    import rcpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] final_index;
    modport source (output valid, output final_index, input ready);
    modport sink (input valid, input final_index, output ready);
endinterface

@@ sv/rcpc_ram.sv @@
// generic single write port ram with registered read
module rcpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/rcpc_rng.sv @@
// xorshift64star generator with a shared 32x32 multiplier
module rcpc_rng import rcpc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  rng_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] seed,
    output logic [WORD_W-1:0] rand_value,
    output logic              done
);

    typedef enum logic [2:0] {P_IDLE, P_XS, P_M0, P_M1, P_M2, P_M3} phase_t;

    phase_t              phase_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   prod_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic                done_reg;
    logic [WORD_W-1:0]   x1, x2, x3;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [WORD_W-1:0]   product;

    // shift and xor step
    always_comb
    begin
        x1 = word_reg ^ (word_reg >> SHIFT_A);
        x2 = x1 ^ (x1 << SHIFT_B);
        x3 = x2 ^ (x2 >> SHIFT_C);
    end

    // operand select for the partial products
    always_comb
    begin
        mul_a = word_reg[HALF_W-1:0];
        mul_b = MIX_MULT[HALF_W-1:0];
        case (phase_reg)
            P_M1:    mul_b = MIX_MULT[WORD_W-1:HALF_W];
            P_M2:    mul_a = word_reg[WORD_W-1:HALF_W];
            default: mul_a = word_reg[HALF_W-1:0];
        endcase
        product = WORD_W'(mul_a) * WORD_W'(mul_b);
    end

    // phase sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            word_reg  <= SEED_RESET;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (ctrl.reload)
                    begin
                        word_reg <= seed;
                    end
                    if (ctrl.draw)
                    begin
                        phase_reg <= P_XS;
                    end
                end
                P_XS:
                begin
                    word_reg  <= x3;
                    phase_reg <= P_M0;
                end
                P_M0:
                begin
                    prod_reg  <= product;
                    phase_reg <= P_M1;
                end
                P_M1:
                begin
                    acc_reg   <= prod_reg;
                    prod_reg  <= product;
                    phase_reg <= P_M2;
                end
                P_M2:
                begin
                    acc_reg   <= acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    prod_reg  <= product;
                    phase_reg <= P_M3;
                end
                P_M3:
                begin
                    acc_reg   <= acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
                    done_reg  <= 1'b1;
                    phase_reg <= P_IDLE;
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    assign rand_value = acc_reg;
    assign done       = done_reg;

endmodule

@@ sv/rcpc_divider.sv @@
// restoring remainder unit, one dividend bit per cycle
module rcpc_divider import rcpc_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic [CNT_W-1:0] remainder,
    output logic             done
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    dividend_reg;
    logic [CNT_W-1:0]     divisor_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;

    // trial subtract
    always_comb
    begin
        trial = {rem_reg, dividend_reg[WORD_W-1]};
        diff  = trial - {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                cnt_reg      <= '0;
                dividend_reg <= req.dividend;
                divisor_reg  <= req.divisor;
                rem_reg      <= '0;
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_reg <= diff[CNT_W-1:0];
                end
                else
                begin
                    rem_reg <= trial[CNT_W-1:0];
                end
                dividend_reg <= dividend_reg << 1;
                cnt_reg      <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

@@ sv/random_cycle_pointer_chase.sv @@
// random cycle pointer chase: shuffle sequencer around the order memory
//
// A transaction on req carries step_count and starts one traversal; one
// transaction on rsp returns final_index for it. Configuration (seed,
// node_count) is written through wr_en/wr_index/wr_data by the user, and
// only while idle; the block itself does not enforce this. The order
// memory is filled with the identity, then shuffled from the top index
// down: per node one generator draw (shared 32x32 multiplier), one 64-step
// remainder pass and a swap through the memory states S_RD_I, S_RD_J,
// S_WR_I and S_WR_J. Since the links follow the shuffled order in a single
// cycle, the warm-up returns to the start node and the chase of step_count
// links lands on order[step_count mod n]; that remainder takes one more
// divider pass and one memory read.
// One item is worked on at a time; req.ready is high while idle, and a
// finished result waits in the output register while the next item runs.
// If the receiver stalls, a further result is held until rsp is free.
// Reset returns the configuration to its defaults and clears control state;
// memory contents need no clearing.
module random_cycle_pointer_chase import rcpc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    rcpc_in_if.sink              req,
    rcpc_out_if.source           rsp,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [WORD_W-1:0]    wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_DRAW, S_WAIT_RNG, S_DIV_SHUF, S_RD_I, S_RD_J,
        S_WR_I, S_WR_J, S_STEPS, S_RD_R, S_LOAD_R, S_HOLD
    } state_t;

    state_t             state_reg;
    logic [WORD_W-1:0]  seed_reg;
    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   n_eff;
    logic [STEP_W-1:0]  steps_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   i_reg;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   fin_reg;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;

    rng_ctrl_t          rng_ctrl;
    logic [WORD_W-1:0]  rand_value;
    logic               rng_done;
    div_req_t           div_req;
    logic [CNT_W-1:0]   rem;
    logic               div_done;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [IDX_W-1:0]   ram_rdata;
    logic               in_fire;

    assign in_fire = req.valid && req.ready;

    // clamp node count
    always_comb
    begin
        n_eff = node_count_reg;
        if (node_count_reg < CNT_W'(2))
        begin
            n_eff = CNT_W'(2);
        end
        else if (node_count_reg > CNT_W'(MAX_NODES))
        begin
            n_eff = CNT_W'(MAX_NODES);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            node_count_reg <= NODE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SEED:       seed_reg       <= wr_data;
                REG_NODE_COUNT: node_count_reg <= wr_data[CNT_W-1:0];
                default:        seed_reg       <= seed_reg;
            endcase
        end
    end

    // unit requests and memory ports
    always_comb
    begin
        rng_ctrl.reload  = in_fire;
        rng_ctrl.draw    = (state_reg == S_DRAW);
        div_req.start    = 1'b0;
        div_req.dividend = rand_value;
        div_req.divisor  = {1'b0, i_reg} + CNT_W'(1);
        ram_we           = 1'b0;
        ram_waddr        = i_reg;
        ram_wdata        = ram_rdata;
        ram_raddr        = i_reg;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = k_reg;
            end
            S_WAIT_RNG:
            begin
                div_req.start = rng_done;
            end
            S_RD_J:
            begin
                ram_raddr = j_reg;
            end
            S_WR_I:
            begin
                ram_we = 1'b1;
            end
            S_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = a_reg;
                if (i_reg == IDX_W'(1))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = WORD_W'(steps_reg);
                    div_req.divisor  = n_eff;
                end
            end
            S_RD_R:
            begin
                ram_raddr = j_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // traversal sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the hold state decides the output register itself
            if (rsp.ready && state_reg != S_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        steps_reg <= req.step_count;
                        k_reg     <= '0;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    if ({1'b0, k_reg} == n_eff - CNT_W'(1))
                    begin
                        i_reg     <= k_reg;
                        state_reg <= S_DRAW;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                S_DRAW:
                begin
                    state_reg <= S_WAIT_RNG;
                end
                S_WAIT_RNG:
                begin
                    if (rng_done)
                    begin
                        state_reg <= S_DIV_SHUF;
                    end
                end
                S_DIV_SHUF:
                begin
                    if (div_done)
                    begin
                        j_reg     <= rem[IDX_W-1:0];
                        state_reg <= S_RD_I;
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_RD_J;
                end
                S_RD_J:
                begin
                    a_reg     <= ram_rdata;
                    state_reg <= S_WR_I;
                end
                S_WR_I:
                begin
                    state_reg <= S_WR_J;
                end
                S_WR_J:
                begin
                    if (i_reg == IDX_W'(1))
                    begin
                        state_reg <= S_STEPS;
                    end
                    else
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= S_DRAW;
                    end
                end
                S_STEPS:
                begin
                    if (div_done)
                    begin
                        j_reg     <= rem[IDX_W-1:0];
                        state_reg <= S_RD_R;
                    end
                end
                S_RD_R:
                begin
                    state_reg <= S_LOAD_R;
                end
                S_LOAD_R:
                begin
                    fin_reg   <= ram_rdata;
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_index_reg <= fin_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.final_index = out_index_reg;

    rcpc_rng u_rng (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rng_ctrl),
        .seed       (seed_reg),
        .rand_value (rand_value),
        .done       (rng_done)
    );

    rcpc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .remainder (rem),
        .done      (div_done)
    );

    rcpc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    ) u_order_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // writes stay inside the active node range
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < n_eff))
        else $error("order memory write beyond node count");

    // remainder results arrive only while a remainder is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_SHUF || state_reg == S_STEPS))
        else $error("unexpected remainder result");

    // a shuffle swap never runs at index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_I) |-> (i_reg != '0))
        else $error("swap at index zero");

    // an accepted item starts the fill pass
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_INIT))
        else $error("accepted item did not start");

endmodule

@@ tb/tb_random_cycle_pointer_chase.sv @@
// testbench for the random cycle pointer chase block
`timescale 1ns / 1ps

module tb_random_cycle_pointer_chase;
    import rcpc_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  RESET_CYCLES = 6;
    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  RANDOM_PHASES = 12;
    localparam int  ITEMS_PER_PHASE = 8;

    // expected final indices, predicted from the shuffled cycle
    class chase_scoreboard;
        logic [WORD_W-1:0] seed_val;
        logic [CNT_W-1:0]  nodes_val;
        logic [IDX_W-1:0]  expected_q[$];

        function new();
            seed_val  = SEED_RESET;
            nodes_val = NODE_RESET;
        endfunction

        // shuffle as the block does, then link and chase the cycle
        function logic [IDX_W-1:0] predict_index(logic [STEP_W-1:0] steps);
            int unsigned       n;
            int unsigned       order[MAX_NODES];
            int unsigned       succ[MAX_NODES];
            logic [WORD_W-1:0] w;
            logic [WORD_W-1:0] r;
            int unsigned       j;
            int unsigned       t;
            int unsigned       cur;
            longint unsigned   rest;
            n = nodes_val;
            if (n < 2) n = 2;
            if (n > MAX_NODES) n = MAX_NODES;
            w = seed_val;
            for (int i = 0; i < n; i++) order[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                w = w ^ (w >> SHIFT_A);
                w = w ^ (w << SHIFT_B);
                w = w ^ (w >> SHIFT_C);
                r = w * MIX_MULT;
                j = int'(r % (64'(i) + 64'd1));
                t = order[i];
                order[i] = order[j];
                order[j] = t;
            end
            for (int i = 0; i < n; i++)
                succ[order[i]] = (i + 1 < n) ? order[i + 1] : order[0];
            cur = order[0];
            for (int k = 0; k < 2 * n; k++) cur = succ[cur];
            rest = longint'(steps) % longint'(n);
            for (longint k = 0; k < rest; k++) cur = succ[cur];
            return IDX_W'(cur);
        endfunction

        function void note_request(logic [STEP_W-1:0] steps);
            expected_q.push_back(predict_index(steps));
        endfunction

        // returns 1 on a mismatch or an unexpected result
        function bit check_result(logic [IDX_W-1:0] got, output string msg);
            logic [IDX_W-1:0] exp_idx;
            if (expected_q.size() == 0)
            begin
                msg = $sformatf("unexpected final_index %0d", got);
                return 1;
            end
            exp_idx = expected_q.pop_front();
            if (got !== exp_idx)
            begin
                msg = $sformatf("final_index %0d, expected %0d", got, exp_idx);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [WORD_W-1:0]    wr_data;
    int                   error_count;
    longint               cycle_count;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    chase_scoreboard      sb;

    rcpc_in_if  req_if ();
    rcpc_out_if rsp_if ();

    random_cycle_pointer_chase u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_if.sink),
        .rsp      (rsp_if.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_random_cycle_pointer_chase failed");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (sb.check_result(rsp_if.final_index, msg)) report_mismatch(msg);
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = value;
        @(negedge clk);
        wr_en = 1'b0;
        if (idx == REG_SEED) sb.seed_val = value;
        else sb.nodes_val = CNT_W'(value);
    endtask

    // one request transaction, with random gaps before it
    task automatic send_request(logic [STEP_W-1:0] steps);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid = 1'b0;
            req_if.step_count = STEP_W'($urandom);
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.step_count = steps;
        do @(posedge clk); while (!req_if.ready);
        sb.note_request(steps);
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    // block is idle once every result is back
    task automatic wait_idle();
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [STEP_W-1:0] random_steps();
        case ($urandom_range(3))
            0: return STEP_W'($urandom_range(40));
            1: return '1 - STEP_W'($urandom_range(3));
            default: return STEP_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [WORD_W-1:0] seed_pick;
        logic [WORD_W-1:0] node_pick;
        sb            = new();
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 22;
        recv_idle_pct = 84;
        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_SEED;
        wr_data       = '0;
        req_if.valid  = 1'b0;
        req_if.step_count = '0;
        rsp_if.ready  = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, full-size cycle
        send_request('1);
        wait_idle();

        // zero seed with an oversized node count
        write_reg(REG_SEED, '0);
        write_reg(REG_NODE_COUNT, 64'h1FFF);
        send_request(STEP_W'(5));
        wait_idle();

        // node count below two, all-ones seed, step extremes
        write_reg(REG_SEED, '1);
        write_reg(REG_NODE_COUNT, 64'd0);
        send_request('0);
        send_request(STEP_W'(1));
        send_request('1);
        send_request(32'h8000_0000);
        wait_idle();

        write_reg(REG_NODE_COUNT, 64'd1);
        write_reg(REG_SEED, 64'd1);
        send_request(STEP_W'(3));
        send_request(32'h5555_5555);
        wait_idle();

        write_reg(REG_NODE_COUNT, 64'd2);
        send_request('0);
        send_request(32'hAAAA_AAAA);
        wait_idle();

        write_reg(REG_NODE_COUNT, 64'd7);
        write_reg(REG_SEED, 64'hDEAD_BEEF_0123_4567);
        send_request(STEP_W'(6));
        send_request(STEP_W'(7));
        send_request(STEP_W'(13));
        send_request(STEP_W'(14));
        send_request('1);
        wait_idle();

        // random phases: small cycles mostly, idling pattern by thirds
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < RANDOM_PHASES / 3)
            begin
                send_idle_pct = 22;
                recv_idle_pct = 84;
            end
            else if (p < 2 * RANDOM_PHASES / 3)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 22;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: seed_pick = '0;
                1: seed_pick = '1;
                default: seed_pick = {32'($urandom), 32'($urandom)};
            endcase
            case ($urandom_range(9))
                0: node_pick = 64'($urandom_range(1));
                1: node_pick = 64'($urandom_range(100, 40));
                default: node_pick = 64'($urandom_range(24, 2));
            endcase
            write_reg(REG_SEED, seed_pick);
            write_reg(REG_NODE_COUNT, node_pick);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) send_request(random_steps());
            wait_idle();
        end

        if (error_count == 0)
            $display("tb_random_cycle_pointer_chase passed");
        else
            $display("tb_random_cycle_pointer_chase failed");
        $finish;
    end

endmodule
